[hw/rtl/dtb_pkg.sv]
// Shared types, constants and helper functions of the digit text to bytes parser.
`default_nettype none

package dtb_pkg;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int CMD_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    localparam logic [3:0] MAX_DIGITS = 4'd8;

    localparam logic [4:0]  NUMBER_BASE_RST      = 5'd16;
    localparam logic [3:0]  DIGITS_PER_GROUP_RST = 4'd2;

    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_CR     = 8'h0D;
    localparam logic [7:0] CHR_LF     = 8'h0A;
    localparam logic [7:0] CHR_NUL    = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUMBER_BASE      = 3'd0,
        REG_DIGITS_PER_GROUP = 3'd1,
        REG_LOWER_CASE       = 3'd2,
        REG_SKIP_GROUPS      = 3'd3,
        REG_LIMIT_ENABLE     = 3'd4,
        REG_LIMIT_COUNT      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_SEP   = 2'd1,
        CLS_BAD   = 2'd2,
        CLS_END   = 2'd3
    } cls_t;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_FLUSH = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [4:0]  number_base;
        logic [3:0]  digits_per_group;
        logic        lower_case_letters;
        logic [31:0] skip_groups;
        logic        limit_enable;
        logic [31:0] limit_count;
    } cfg_t;

    // val: digit value for CLS_DIGIT, raw character for CLS_BAD
    typedef struct packed {
        cls_t       cls;
        logic [7:0] val;
    } cmd_t;

    typedef struct packed {
        logic [7:0] byte_value;
        kind_t      kind;
        logic       last;
    } res_t;

    function automatic logic [4:0] eff_base(input logic [4:0] b);
        logic [4:0] r;
        if (b < 5'd2)
            r = 5'd2;
        else if (b > 5'd16)
            r = 5'd16;
        else
            r = b;
        return r;
    endfunction

    function automatic logic [3:0] eff_width(input logic [3:0] w);
        logic [3:0] r;
        if (w == 4'd0)
            r = 4'd1;
        else if (w > MAX_DIGITS)
            r = MAX_DIGITS;
        else
            r = w;
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/dtb_fifo.sv]
// Small first-word-fall-through queue used between front, back and result port.
`default_nettype none

module dtb_fifo
    import dtb_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   full,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      rd_data,
    output logic                   empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_ADDR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

[hw/rtl/dtb_front.sv]
// Front end: accepts characters and classifies them into digit, separator, bad or end.
`default_nettype none

module dtb_front
    import dtb_pkg::*;
(
    input  wire logic       push,
    input  wire logic [7:0] text_char,
    input  wire logic       stream_end,
    input  wire logic [4:0] number_base,
    input  wire logic       lower_case_letters,
    input  wire logic       cmd_full,
    output logic            cmd_push,
    output cmd_t            cmd
);

    logic [4:0] base;
    logic [7:0] letter_a;
    logic [7:0] dig_val;
    logic       is_num;
    logic       is_letter;
    logic       is_sep;
    logic       is_digit;

    assign base      = eff_base(number_base);
    assign letter_a  = lower_case_letters ? CHR_LOWER_A : CHR_UPPER_A;
    assign is_num    = (text_char >= CHR_ZERO) && (text_char <= CHR_NINE);
    assign is_letter = (text_char >= letter_a) && (text_char <= letter_a + 8'd5);
    assign is_sep    = (text_char == CHR_SPACE) || (text_char == CHR_TAB)
                    || (text_char == CHR_CR) || (text_char == CHR_LF)
                    || (text_char == CHR_NUL);

    always_comb
    begin
        dig_val = 8'd16;
        if (is_num)
            dig_val = text_char - CHR_ZERO;
        else if (is_letter)
            dig_val = text_char - letter_a + 8'd10;
    end

    assign is_digit = (is_num || is_letter) && (dig_val < {3'b000, base});
    assign cmd_push = push && !cmd_full;

    always_comb
    begin
        cmd.val = text_char;
        priority if (stream_end)
            cmd.cls = CLS_END;
        else if (is_digit)
        begin
            cmd.cls = CLS_DIGIT;
            cmd.val = dig_val;
        end
        else if (is_sep)
            cmd.cls = CLS_SEP;
        else
            cmd.cls = CLS_BAD;
    end

endmodule

`default_nettype wire

[hw/rtl/dtb_back.sv]
// Back end: accumulates digits, closes groups, applies skip and limit, builds results.
`default_nettype none

module dtb_back
    import dtb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic cmd_empty,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire logic res_full,
    output logic      res_push,
    output res_t      res
);

    back_state_t state_reg, state_next;
    logic [7:0]  acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] emit_reg, emit_next;
    logic        lstop_reg, lstop_next;
    logic        estop_reg, estop_next;

    logic [4:0]  base;
    logic [3:0]  width;
    logic [12:0] prod;
    logic [7:0]  acc_new;
    logic [3:0]  cnt_new;
    logic        stopped;
    logic        go;
    logic        closes;
    logic        flush_ok;
    logic        at_limit;

    assign base     = eff_base(cfg.number_base);
    assign width    = eff_width(cfg.digits_per_group);
    assign prod     = 13'(acc_reg) * 13'(base);
    assign acc_new  = prod[7:0] + cmd.val;
    assign cnt_new  = cnt_reg + 4'd1;
    assign stopped  = lstop_reg || estop_reg;
    assign go       = !cmd_empty && !res_full;
    assign at_limit = cfg.limit_enable && (emit_reg == cfg.limit_count);
    assign closes   = ((cmd.cls == CLS_DIGIT) && (cnt_new >= width))
                   || ((cmd.cls == CLS_SEP) && (cnt_reg != 4'd0));
    assign flush_ok = (cnt_reg != 4'd0) && (skip_reg == '0) && !stopped
                   && (!cfg.limit_enable || (emit_reg < cfg.limit_count));

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        skip_next      = skip_reg;
        emit_next      = emit_reg;
        lstop_next     = lstop_reg;
        estop_next     = estop_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res.byte_value = acc_reg;
        res.kind       = KIND_DATA;
        res.last       = 1'b1;
        if (go)
        begin
            unique case (cmd.cls)
                CLS_END:
                begin
                    res_push = 1'b1;
                    if (state_reg == ST_RUN && flush_ok)
                    begin
                        res.last   = 1'b0;
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        res.byte_value = '0;
                        res.kind       = KIND_END;
                        cmd_pop        = 1'b1;
                        state_next     = ST_RUN;
                        acc_next       = '0;
                        cnt_next       = '0;
                        skip_next      = cfg.skip_groups;
                        emit_next      = '0;
                        lstop_next     = 1'b0;
                        estop_next     = 1'b0;
                    end
                end
                CLS_BAD:
                begin
                    cmd_pop = 1'b1;
                    if (!stopped)
                    begin
                        res_push       = 1'b1;
                        res.byte_value = cmd.val;
                        res.kind       = KIND_ERROR;
                        estop_next     = 1'b1;
                        acc_next       = '0;
                        cnt_next       = '0;
                    end
                end
                CLS_DIGIT, CLS_SEP:
                begin
                    cmd_pop = 1'b1;
                    if (!stopped)
                    begin
                        if (cmd.cls == CLS_DIGIT)
                        begin
                            acc_next       = acc_new;
                            cnt_next       = cnt_new;
                            res.byte_value = acc_new;
                        end
                        if (closes)
                        begin
                            acc_next = '0;
                            cnt_next = '0;
                            priority if (skip_reg != '0)
                                skip_next = skip_reg - 32'd1;
                            else if (at_limit)
                                lstop_next = 1'b1;
                            else
                            begin
                                res_push = 1'b1;
                                if (cfg.limit_enable)
                                    emit_next = emit_reg + 32'd1;
                            end
                        end
                    end
                end
                default:
                begin
                    cmd_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            skip_reg  <= '0;
            emit_reg  <= '0;
            lstop_reg <= 1'b0;
            estop_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            emit_reg  <= emit_next;
            lstop_reg <= lstop_next;
            estop_reg <= estop_next;
        end
    end

    a_flush_holds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (!cmd_empty && cmd.cls == CLS_END))
        else $error("flush state without a pending end command");

    a_count_below_group: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < MAX_DIGITS)
        else $error("digit count reached a full group without closing");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result transfer into a full queue");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind == KIND_ERROR) |=> estop_reg)
        else $error("error result did not stop the stream");

endmodule

`default_nettype wire

[hw/rtl/digit_text_to_bytes.sv]
// Top level of the digit text to bytes parser: config registers, front, queues, back.
//
// Input channel: one character per transfer (text_char, or stream_end=1 to end a
// stream), taken at a clock edge with push high and full low.
// Result channel: byte_value, result_kind, last_result of the oldest result are
// shown while empty is low and leave at an edge with pop high.
// Config: cfg_write with cfg_index/cfg_data writes one register per edge; the user
// must write only while no item is in flight; the block itself does not enforce it.
// Throughput: one character per cycle while the result queue has room; an end of
// stream that flushes a partial group makes two results and holds its end command.
// A taken character is written into the command queue; the back end reads it from
// the queue head and writes its result into the result queue, whose head is shown
// on the result ports and can leave from there.
// When the receiver stalls, the result queue fills, the back end holds, the
// command queue fills and full rises; nothing is dropped.
// Reset clears the queues, the parse state and restores register defaults.
`default_nettype none

module digit_text_to_bytes
    import dtb_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int RES_DEPTH = RES_DEPTH_DEF
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [7:0]             text_char,
    input  wire logic                   stream_end,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [7:0]                  byte_value,
    output logic [1:0]                  result_kind,
    output logic                        last_result,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [4:0]  number_base_reg;
    logic [3:0]  digits_per_group_reg;
    logic        lower_case_reg;
    logic [31:0] skip_groups_reg;
    logic        limit_enable_reg;
    logic [31:0] limit_count_reg;
    cfg_t        cfg;

    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t cmd_in, cmd_out;
    logic res_push, res_full;
    res_t res_in, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg      <= NUMBER_BASE_RST;
            digits_per_group_reg <= DIGITS_PER_GROUP_RST;
            lower_case_reg       <= 1'b0;
            skip_groups_reg      <= '0;
            limit_enable_reg     <= 1'b0;
            limit_count_reg      <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUMBER_BASE:      number_base_reg      <= cfg_data[4:0];
                REG_DIGITS_PER_GROUP: digits_per_group_reg <= cfg_data[3:0];
                REG_LOWER_CASE:       lower_case_reg       <= cfg_data[0];
                REG_SKIP_GROUPS:      skip_groups_reg      <= cfg_data[31:0];
                REG_LIMIT_ENABLE:     limit_enable_reg     <= cfg_data[0];
                REG_LIMIT_COUNT:      limit_count_reg      <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.number_base        = number_base_reg;
    assign cfg.digits_per_group   = digits_per_group_reg;
    assign cfg.lower_case_letters = lower_case_reg;
    assign cfg.skip_groups        = skip_groups_reg;
    assign cfg.limit_enable       = limit_enable_reg;
    assign cfg.limit_count        = limit_count_reg;

    assign full = cmd_full;

    dtb_front u_front (
        .push               (push),
        .text_char          (text_char),
        .stream_end         (stream_end),
        .number_base        (number_base_reg),
        .lower_case_letters (lower_case_reg),
        .cmd_full           (cmd_full),
        .cmd_push           (cmd_push),
        .cmd                (cmd_in)
    );

    dtb_fifo #(
        .DATA_W ($bits(cmd_t)),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    dtb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    dtb_fifo #(
        .DATA_W ($bits(res_t)),
        .DEPTH  (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign byte_value  = res_out.byte_value;
    assign result_kind = res_out.kind;
    assign last_result = res_out.last;

endmodule

`default_nettype wire
